FILE: rtl/ttu_pkg.sv
`default_nettype none

package ttu_pkg;

    localparam int unsigned TICK_W     = 32;
    localparam int unsigned NOW_W      = 64;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned SEC_W      = 32;
    localparam int unsigned USEC_W     = 20;

    localparam int unsigned DIV_STEPS  = 64;
    localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

    localparam logic [31:0] FREQ_RESET   = 32'd32772000;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_SEC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_USEC   = 2'd2;

    typedef struct packed {
        logic capture;
        logic set_base;
        logic diff;
        logic mul_a;
        logic load_d;
        logic div_step;
        logic load_us;
        logic add_ref;
        logic finish;
    } ttu_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ttu_ctrl.sv
`default_nettype none

module ttu_ctrl
    import ttu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     func,
    output logic          busy,
    output logic          done,
    output ttu_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SET   = 4'd1;
    localparam logic [3:0] S_DIFF  = 4'd2;
    localparam logic [3:0] S_MULA  = 4'd3;
    localparam logic [3:0] S_MULB  = 4'd4;
    localparam logic [3:0] S_DIV1  = 4'd5;
    localparam logic [3:0] S_MULUS = 4'd6;
    localparam logic [3:0] S_DIV2  = 4'd7;
    localparam logic [3:0] S_ADD   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic             accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = func ? S_DIFF : S_SET;
                end
            end
            S_SET:
            begin
                cmd.set_base = 1'b1;
                state_next   = S_IDLE;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MULA;
            end
            S_MULA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.load_d = 1'b1;
                state_next = S_DIV1;
            end
            S_DIV1, S_DIV2:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = (state_reg == S_DIV1) ? S_MULUS : S_ADD;
                end
            end
            S_MULUS:
            begin
                cmd.load_us = 1'b1;
                state_next  = S_DIV2;
            end
            S_ADD:
            begin
                cmd.add_ref = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

`ifndef ASSERT_OFF
    a_set_path: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !func |=> state_reg == S_SET)
        else $error("set transfer did not go to base update");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV1 && cnt_reg == CNT_LAST |=> state_reg == S_MULUS)
        else $error("first division did not end after last step");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg && $past(state_reg, 2) == S_OUT)
        else $error("result strobe not a single cycle after output state");
`endif

endmodule

`default_nettype wire

FILE: rtl/ttu_dp.sv
`default_nettype none

module ttu_dp
    import ttu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ttu_cmd_t              cmd,
    input  wire logic [TICK_W-1:0]     tick,
    input  wire logic [NOW_W-1:0]      now_ticks,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic [SEC_W-1:0]           seconds,
    output logic [USEC_W-1:0]          microseconds
);

    logic [31:0]       freq_reg;
    logic [31:0]       rsec_reg;
    logic [USEC_W-1:0] rus_reg;
    logic [63:0]       base_reg;

    logic [63:0]       ext_reg,  ext_next;
    logic [63:0]       diff_reg, diff_next;
    logic [63:0]       t_reg,    t_next;
    logic [31:0]       rem_reg,  rem_next;
    logic [63:0]       quo_reg,  quo_next;
    logic [31:0]       secq_reg, secq_next;
    logic [SEC_W-1:0]  ssum_reg, ssum_next;
    logic [USEC_W:0]   usum_reg, usum_next;
    logic [SEC_W-1:0]  sec_reg,  sec_next;
    logic [USEC_W-1:0] us_reg,   us_next;

    logic [31:0] f_eff;
    logic        borrow;
    logic [32:0] trial;
    logic [32:0] trial_sub;
    logic [51:0] us_prod;

    assign f_eff     = (freq_reg == '0) ? 32'd1 : freq_reg;
    assign borrow    = !now_ticks[31] && tick[31];
    assign trial     = {rem_reg, quo_reg[63]};
    assign trial_sub = trial - {1'b0, f_eff};
    assign us_prod   = 52'(rem_reg) * 52'(USEC_PER_SEC);

    always_comb
    begin
        ext_next  = ext_reg;
        diff_next = diff_reg;
        t_next    = t_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        secq_next = secq_reg;
        ssum_next = ssum_reg;
        usum_next = usum_reg;
        sec_next  = sec_reg;
        us_next   = us_reg;
        if (cmd.capture)
        begin
            ext_next = {now_ticks[63:32] - {31'b0, borrow}, tick};
        end
        if (cmd.diff)
        begin
            diff_next = ext_reg - base_reg;
        end
        if (cmd.mul_a)
        begin
            t_next = (diff_reg << 4) + (diff_reg << 3);
        end
        if (cmd.load_d)
        begin
            quo_next = (diff_reg << 10) - t_reg;
            rem_next = '0;
        end
        if (cmd.div_step)
        begin
            if (!trial_sub[32])
            begin
                rem_next = trial_sub[31:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
        end
        if (cmd.load_us)
        begin
            secq_next = quo_reg[31:0];
            quo_next  = {12'b0, us_prod};
            rem_next  = '0;
        end
        if (cmd.add_ref)
        begin
            ssum_next = secq_reg + rsec_reg;
            usum_next = {1'b0, quo_reg[USEC_W-1:0]} + {1'b0, rus_reg};
        end
        if (cmd.finish)
        begin
            if (usum_reg >= {1'b0, USEC_PER_SEC})
            begin
                sec_next = ssum_reg + 1'b1;
                us_next  = USEC_W'(usum_reg - {1'b0, USEC_PER_SEC});
            end
            else
            begin
                sec_next = ssum_reg;
                us_next  = usum_reg[USEC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ext_reg  <= ext_next;
        diff_reg <= diff_next;
        t_reg    <= t_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        secq_reg <= secq_next;
        ssum_reg <= ssum_next;
        usum_reg <= usum_next;
        sec_reg  <= sec_next;
        us_reg   <= us_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= FREQ_RESET;
            rsec_reg <= '0;
            rus_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FREQ_SCALE: freq_reg <= cfg_data;
                    REG_REF_SEC:    rsec_reg <= cfg_data;
                    REG_REF_USEC:   rus_reg  <= cfg_data[USEC_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.set_base)
            begin
                base_reg <= ext_reg;
            end
        end
    end

    assign seconds      = sec_reg;
    assign microseconds = us_reg;

`ifndef ASSERT_OFF
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> rem_reg < f_eff)
        else $error("division remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: rtl/tick_timestamp_to_unix_time.sv
`default_nettype none

// converts 32-bit timer ticks to unix seconds and microseconds
// command channel: an item transfers at a rising edge with start high and busy low;
//   func 0 extends tick against now_ticks and stores it as the base, no result
//   func 1 converts the extended tick, relative to the base, to unix time
// result channel: seconds and microseconds are valid for the single cycle in which
//   done is high; the receiver cannot stall, so nothing waits on it
// result timing: a convert result shows when done rises, and busy falls in that same
//   cycle, so a new convert is not taken until the last one has finished
// a set item holds busy only for the base update state, then returns to idle
// a convert runs two passes of one shared restoring divider, 64 steps each,
//   one quotient bit per cycle, for seconds and then for microseconds
// configuration: cfg_we writes cfg_data to register cfg_index at once
//   (0 frequency_scale, 1 ref_seconds, 2 ref_microseconds); write only while idle
// reset: frequency_scale returns to 32772000, references and base to zero,
//   the controller to idle with done low

module tick_timestamp_to_unix_time
    import ttu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  func,
    input  wire logic [TICK_W-1:0]     tick,
    input  wire logic [NOW_W-1:0]      now_ticks,
    output logic                       done,
    output logic [SEC_W-1:0]           seconds,
    output logic [USEC_W-1:0]          microseconds,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ttu_cmd_t cmd;

    ttu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    ttu_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .tick         (tick),
        .now_ticks    (now_ticks),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .seconds      (seconds),
        .microseconds (microseconds)
    );

endmodule

`default_nettype wire

FILE: test/tick_timestamp_to_unix_time_tb.sv
`timescale 1ns / 1ps

module tick_timestamp_to_unix_time_tb;
    import ttu_pkg::*;

    localparam logic FUNC_SET     = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned CONVERT_WAIT = 140;
    localparam int unsigned PHASE_ITEMS  = 290;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
    } unix_time_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  func;
    logic [TICK_W-1:0]     tick;
    logic [NOW_W-1:0]      now_ticks;
    logic                  done;
    logic [SEC_W-1:0]      seconds;
    logic [USEC_W-1:0]     microseconds;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state and register copies
    logic [31:0]       freq_scale;
    logic [31:0]       ref_sec;
    logic [19:0]       ref_usec;
    logic [63:0]       base_tick;
    logic [63:0]       timeline;

    unix_time_t        expected_times[$];
    int unsigned       error_count;
    int unsigned       set_count;
    int unsigned       convert_count;
    int unsigned       checked_count;
    int unsigned       setting_count;
    int unsigned       cycle_count;

    tick_timestamp_to_unix_time uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .tick         (tick),
        .now_ticks    (now_ticks),
        .done         (done),
        .seconds      (seconds),
        .microseconds (microseconds),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] extend_tick(input logic [31:0] t, input logic [63:0] n);
        logic [63:0] full;
        full = {n[63:32], t};
        if (!n[31] && t[31])
            full = full - 64'h1_0000_0000;
        return full;
    endfunction

    function automatic unix_time_t to_unix_time(input logic [63:0] ext);
        logic [63:0] divisor;
        logic [63:0] scaled;
        logic [63:0] rem;
        logic [63:0] usec_part;
        logic [31:0] sec;
        logic [31:0] usec;
        unix_time_t  res;
        divisor   = (freq_scale == 32'd0) ? 64'd1 : {32'd0, freq_scale};
        scaled    = (ext - base_tick) * 64'd1000;
        sec       = 32'(scaled / divisor);
        rem       = scaled % divisor;
        usec_part = (rem * 64'd1000000) / divisor;
        sec       = sec + ref_sec;
        usec      = usec_part[31:0] + {12'd0, ref_usec};
        if (usec >= 32'd1000000)
        begin
            sec  = sec + 32'd1;
            usec = usec - 32'd1000000;
        end
        res.sec  = sec;
        res.usec = usec[19:0];
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_FREQ_SCALE: freq_scale = val;
            REG_REF_SEC:    ref_sec    = val;
            REG_REF_USEC:   ref_usec   = val[19:0];
            default:        ;
        endcase
    endtask

    task automatic send_item(input logic f, input logic [31:0] t, input logic [63:0] n);
        logic [63:0] ext;
        @(negedge clk);
        start     <= 1'b1;
        func      <= f;
        tick      <= t;
        now_ticks <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ext = extend_tick(t, n);
        if (f == FUNC_SET)
        begin
            base_tick = ext;
            set_count++;
        end
        else
        begin
            expected_times.push_back(to_unix_time(ext));
            convert_count++;
        end
    endtask

    task automatic idle_gap(input int unsigned pct);
        int unsigned len;
        if ($urandom_range(0, 99) < pct)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 4);
            @(negedge clk);
            start <= 1'b0;
            repeat (len - 1)
                @(negedge clk);
        end
    endtask

    // hold off until every pending conversion has come back and the block is idle
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (expected_times.size() != 0 || busy)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] f, input logic [31:0] s,
                                 input logic [31:0] us);
        wait_idle();
        write_reg(REG_FREQ_SCALE, f);
        write_reg(REG_REF_SEC, s);
        write_reg(REG_REF_USEC, us);
        setting_count++;
    endtask

    task automatic test_reset_defaults();
        send_item(FUNC_CONVERT, 32'd0, 64'd0);
        send_item(FUNC_CONVERT, 32'd32772, 64'd32772);
    endtask

    task automatic test_tick_extension();
        send_item(FUNC_SET, 32'hFFFF_FFFF, 64'd0);
        send_item(FUNC_CONVERT, 32'd0, 64'd0);
        send_item(FUNC_SET, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FUNC_CONVERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FUNC_SET, 32'h8000_0000, 64'h0000_0001_7FFF_FFFF);
        send_item(FUNC_CONVERT, 32'h7FFF_FFFF, 64'h0000_0001_8000_0000);
        send_item(FUNC_CONVERT, 32'h8000_0000, 64'h0000_0005_8000_0000);
        // elapsed time below the base
        send_item(FUNC_CONVERT, 32'd0, 64'd0);
    endtask

    task automatic test_register_extremes();
        load_settings(32'd1, 32'hFFFF_FFFF, 32'd999999);
        send_item(FUNC_SET, 32'd0, 64'd0);
        send_item(FUNC_CONVERT, 32'd10, 64'd10);
        wait_idle();
        write_reg(REG_FREQ_SCALE, 32'hFFFF_FFFF);
        send_item(FUNC_CONVERT, 32'hFFFF_FFFF, 64'h1234_5678_FFFF_FFFF);
        wait_idle();
        // seconds wrap on the reference add and then take the microsecond carry
        write_reg(REG_FREQ_SCALE, 32'd3);
        send_item(FUNC_CONVERT, 32'd1, 64'd1);
    endtask

    task automatic test_zero_frequency();
        wait_idle();
        write_reg(REG_FREQ_SCALE, 32'd0);
        send_item(FUNC_CONVERT, 32'd5, 64'd5);
        send_item(FUNC_CONVERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_ref_usec_overflow();
        load_settings(32'd3, 32'd0, 32'hFFF0_0000 | 32'h000F_FFFF);
        send_item(FUNC_CONVERT, 32'd1, 64'd1);
        send_item(FUNC_CONVERT, 32'd2, 64'd2);
    endtask

    task automatic random_phase(input logic [31:0] f, input logic [31:0] s,
                                input logic [31:0] us, input int unsigned idle_pct);
        int unsigned kind;
        logic        fn;
        logic [31:0] t;
        logic [63:0] n;
        logic [31:0] lag;
        load_settings(f, s, us);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                fn = 1'($urandom_range(0, 1));
                t  = $urandom;
                n  = {$urandom, $urandom};
            end
            else
            begin
                if (kind < 24)
                    timeline = {$urandom, $urandom};
                else if ($urandom_range(0, 3) == 0)
                    timeline = timeline + {32'd0, $urandom};
                else
                    timeline = timeline + 64'($urandom_range(0, 1 << 22));
                lag = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                                  : $urandom_range(0, 1 << 20);
                fn  = ($urandom_range(0, 3) != 0) ? FUNC_CONVERT : FUNC_SET;
                t   = timeline[31:0] - lag;
                n   = timeline;
            end
            send_item(fn, t, n);
            idle_gap(idle_pct);
            if (idle_pct == 66 && i == PHASE_ITEMS / 2)
                wait_idle();
        end
    endtask

    task automatic test_random();
        timeline = {$urandom, $urandom};
        random_phase(32'd32768000, $urandom, $urandom_range(0, 999999), 0);
        random_phase(32'd1, 32'd0, 32'd0, 66);
        random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd999999, 14);
        random_phase($urandom, $urandom, $urandom_range(0, 999999), 66);
        random_phase(32'd0, $urandom, 32'h000F_FFFF, 0);
        random_phase($urandom_range(1000, 100000000), $urandom, $urandom, 14);
    endtask

    // every result is checked against the oldest pending conversion
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_times.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %0d s %0d us",
                         $time, seconds, microseconds);
                error_count++;
            end
            else
            begin
                unix_time_t exp_t;
                exp_t = expected_times.pop_front();
                checked_count++;
                if (seconds !== exp_t.sec)
                begin
                    $display("%0t: seconds mismatch, expected %0d, got %0d",
                             $time, exp_t.sec, seconds);
                    error_count++;
                end
                if (microseconds !== exp_t.usec)
                begin
                    $display("%0t: microseconds mismatch, expected %0d, got %0d",
                             $time, exp_t.usec, microseconds);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results pending",
                 $time, cycle_count, expected_times.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = FUNC_SET;
        tick          = '0;
        now_ticks     = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_FREQ_SCALE;
        cfg_data      = '0;
        freq_scale    = FREQ_RESET;
        ref_sec       = '0;
        ref_usec      = '0;
        base_tick     = '0;
        timeline      = '0;
        error_count   = 0;
        set_count     = 0;
        convert_count = 0;
        checked_count = 0;
        setting_count = 1;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_tick_extension();
        test_register_extremes();
        test_zero_frequency();
        test_ref_usec_overflow();
        test_random();

        wait_idle();
        repeat (CONVERT_WAIT)
            @(posedge clk);
        if (expected_times.size() != 0)
        begin
            $display("%0t: %0d conversions never returned", $time, expected_times.size());
            error_count++;
        end
        $display("covered %0d base sets and %0d conversions (%0d checked)",
                 set_count, convert_count, checked_count);
        $display("across %0d register settings incl. zero and full-scale divisors",
                 setting_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ttu_pkg.sv
rtl/ttu_ctrl.sv
rtl/ttu_dp.sv
rtl/tick_timestamp_to_unix_time.sv
test/tick_timestamp_to_unix_time_tb.sv
